// File: sv/assert_macros.svh
// assertion macros used by the top level rtl file of the priority queue
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside reset
`define SPQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// check on every clock edge, reset included
`define SPQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// File: sv/spq_pkg.sv
// shared types and constants of the sorted insert priority queue
`default_nettype none

package spq_pkg;

   // default number of entries
   localparam int DEPTH_DEFAULT = 16;

   // payload widths
   localparam int VALUE_W = 32;
   localparam int PRIO_W = 31;
   localparam int STATUS_W = 2;

   // command codes
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_PRIO = 2'd3;

   // broadcast from the control to every cell of the chain
   typedef struct packed {
      logic push;
      logic signed [VALUE_W-1:0] value;
      logic [PRIO_W-1:0] prio;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// File: sv/spq_if.sv
// request and response channel interfaces of the priority queue
`default_nettype none

interface spq_req_if;
   logic valid;
   logic ready;
   logic cmd;
   logic signed [spq_pkg::VALUE_W-1:0] value;
   logic [spq_pkg::PRIO_W-1:0] priority_req;

   modport source (output valid, cmd, value, priority_req, input ready);
   modport sink (input valid, cmd, value, priority_req, output ready);
endinterface

interface spq_rsp_if #(
   parameter int CW = $clog2(spq_pkg::DEPTH_DEFAULT + 1)
);
   logic valid;
   logic ready;
   logic signed [spq_pkg::VALUE_W-1:0] popped_value;
   logic signed [spq_pkg::VALUE_W-1:0] tail_value;
   logic [spq_pkg::STATUS_W-1:0] status;
   logic [CW-1:0] entry_count;

   modport source (output valid, popped_value, tail_value, status, entry_count, input ready);
   modport sink (input valid, popped_value, tail_value, status, entry_count, output ready);
endinterface

`default_nettype wire

// File: sv/spq_cell.sv
// one slot of the sorted chain: holds an entry and shifts toward the tail on insert
`default_nettype none

module spq_cell #(
   parameter int IDX = 0,
   parameter int CW = 5
) (
   input  wire                                  clock,
   input  spq_pkg::cell_ctrl_type               ctrl,
   input  wire  [CW-1:0]                        count,
   input  wire                                  prev_take,
   input  wire  signed [spq_pkg::VALUE_W-1:0]   prev_value,
   input  wire  [spq_pkg::PRIO_W-1:0]           prev_prio,
   output logic                                 take,
   output logic signed [spq_pkg::VALUE_W-1:0]   value,
   output logic [spq_pkg::PRIO_W-1:0]           prio
);

   logic signed [spq_pkg::VALUE_W-1:0] value_ff;
   logic signed [spq_pkg::VALUE_W-1:0] value_in;
   logic [spq_pkg::PRIO_W-1:0] prio_ff;
   logic [spq_pkg::PRIO_W-1:0] prio_in;
   logic occupied;
   logic at_end;

   // this slot changes on an insert if the new entry lands here or ahead of it
   always_comb begin
      occupied = CW'(IDX) < count;
      at_end = CW'(IDX) == count;
      take = (occupied && (ctrl.prio >= prio_ff)) || at_end;
   end

   // shift from the neighbor when the insert point is ahead, else load the new entry
   always_comb begin
      value_in = value_ff;
      prio_in = prio_ff;
      if (ctrl.push && take) begin
         if (prev_take) begin
            value_in = prev_value;
            prio_in = prev_prio;
         end else begin
            value_in = ctrl.value;
            prio_in = ctrl.prio;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      prio_ff <= prio_in;
   end

   assign value = value_ff;
   assign prio = prio_ff;

endmodule

`default_nettype wire

// File: sv/sorted_insert_priority_queue.sv
// top level of the sorted insert priority queue: control, cell chain and response register
//
//   channel | direction | payload
//   req     | in        | cmd, value, priority_req
//   rsp     | out       | popped_value, tail_value, status, entry_count
//
// the response is offered after the chain and count update and then the tail read
// into the response register; a new request is taken as the response leaves
// reset clears the fill count and the control; entry contents stay as they are
// a stalled response holds the request side off until it is taken
`default_nettype none
`include "assert_macros.svh"

module sorted_insert_priority_queue #(
   parameter int DEPTH = spq_pkg::DEPTH_DEFAULT,
   parameter int CW = $clog2(DEPTH + 1)
) (
   input wire clock,
   input wire reset,
   spq_req_if.sink req,
   spq_rsp_if.source rsp
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_LOAD = 3'b010,
      ST_SEND = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [spq_pkg::STATUS_W-1:0] status_ff;
   logic [spq_pkg::STATUS_W-1:0] status_in;
   logic pop_ff;
   logic pop_in;

   logic signed [spq_pkg::VALUE_W-1:0] popped_ff;
   logic signed [spq_pkg::VALUE_W-1:0] popped_in;
   logic signed [spq_pkg::VALUE_W-1:0] tail_ff;
   logic signed [spq_pkg::VALUE_W-1:0] tail_in;
   logic [spq_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [CW-1:0] rsp_count_ff;

   logic accept;
   logic is_full;
   logic is_empty;
   logic push_ok;
   logic pop_ok;
   spq_pkg::cell_ctrl_type ctrl;

   logic take [DEPTH];
   logic signed [spq_pkg::VALUE_W-1:0] cell_value [DEPTH];
   logic [spq_pkg::PRIO_W-1:0] cell_prio [DEPTH];

   // request decode
   always_comb begin
      accept = req.valid && req.ready;
      is_full = count_ff == CW'(DEPTH);
      is_empty = count_ff == '0;
      push_ok = accept && (req.cmd == spq_pkg::CMD_PUSH) && !is_full
         && (req.priority_req != '0);
      pop_ok = accept && (req.cmd == spq_pkg::CMD_POP) && !is_empty;
      ctrl.push = push_ok;
      ctrl.value = req.value;
      ctrl.prio = req.priority_req;
   end

   // status and fill count of the transaction
   always_comb begin
      status_in = status_ff;
      pop_in = pop_ff;
      count_in = count_ff;
      if (accept) begin
         pop_in = pop_ok;
         if (req.cmd == spq_pkg::CMD_POP) begin
            status_in = is_empty ? spq_pkg::STATUS_EMPTY : spq_pkg::STATUS_OK;
         end else if (is_full) begin
            status_in = spq_pkg::STATUS_FULL;
         end else if (req.priority_req == '0) begin
            status_in = spq_pkg::STATUS_ZERO_PRIO;
         end else begin
            status_in = spq_pkg::STATUS_OK;
         end
      end
      if (push_ok) begin
         count_in = count_ff + CW'(1);
      end else if (pop_ok) begin
         count_in = count_ff - CW'(1);
      end
   end

   // chain of cells, slot zero at the head
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         spq_cell #(
            .IDX (i),
            .CW  (CW)
         ) u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .count      (count_ff),
            .prev_take  (1'b0),
            .prev_value ('0),
            .prev_prio  ('0),
            .take       (take[i]),
            .value      (cell_value[i]),
            .prio       (cell_prio[i])
         );
      end else begin : g_body
         spq_cell #(
            .IDX (i),
            .CW  (CW)
         ) u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .count      (count_ff),
            .prev_take  (take[i-1]),
            .prev_value (cell_value[i-1]),
            .prev_prio  (cell_prio[i-1]),
            .take       (take[i]),
            .value      (cell_value[i]),
            .prio       (cell_prio[i])
         );
      end
   end

   // tail and popped entry selected by the updated count
   always_comb begin
      tail_in = '0;
      popped_in = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (count_ff == CW'(i + 1)) begin
            tail_in = cell_value[i];
         end
         if (pop_ff && (count_ff == CW'(i))) begin
            popped_in = cell_value[i];
         end
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (accept) begin
               state_in = ST_LOAD;
            end else if (rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         status_ff <= spq_pkg::STATUS_OK;
         pop_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         status_ff <= status_in;
         pop_ff <= pop_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD) begin
         popped_ff <= popped_in;
         tail_ff <= tail_in;
         rsp_status_ff <= status_ff;
         rsp_count_ff <= count_ff;
      end
   end

   assign req.ready = (state_ff == ST_IDLE) || ((state_ff == ST_SEND) && rsp.ready);
   assign rsp.valid = state_ff == ST_SEND;
   assign rsp.popped_value = popped_ff;
   assign rsp.tail_value = tail_ff;
   assign rsp.status = rsp_status_ff;
   assign rsp.entry_count = rsp_count_ff;

   // checks
   `SPQ_ASSERT(a_count_bound, count_ff <= CW'(DEPTH), "fill count above depth")
   `SPQ_ASSERT(a_push_count, push_ok |=> count_ff == $past(count_ff) + CW'(1), "push did not grow count")
   `SPQ_ASSERT(a_pop_count, pop_ok |=> count_ff == $past(count_ff) - CW'(1), "pop did not shrink count")
   `SPQ_ASSERT(a_ok_status, (rsp.valid && (rsp.status == spq_pkg::STATUS_OK) && (rsp.entry_count == '0)) |-> (rsp.tail_value == '0), "empty queue reports a tail")

   for (genvar i = 0; i + 1 < DEPTH; i++) begin : g_order_chk
      `SPQ_ASSERT(a_sorted, (count_ff > CW'(i + 1)) |-> (cell_prio[i] >= cell_prio[i+1]), "chain out of priority order")
   end

endmodule

`default_nettype wire
